@@ src/tli_pkg.sv @@
`timescale 1ns / 1ps

package tli_pkg;

	localparam int TLI_TABLE_DEPTH = 64;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] REGION_EMPTY  = 2'd0;
	localparam logic [1:0] REGION_BELOW  = 2'd1;
	localparam logic [1:0] REGION_ABOVE  = 2'd2;
	localparam logic [1:0] REGION_INTERP = 2'd3;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
	} div_status_t;

endpackage

@@ src/tli_divider.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The upper half of the dividend
// must be below the divisor, so the quotient fits in 32 bits.
module tli_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tli_pkg::div_req_t     req,
	output tli_pkg::div_status_t  status,
	output logic [31:0]           quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] low_q;
	logic [31:0] den_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        qbit;

	always_comb begin
		trial = {rem_q, low_q[31]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[63:32];
			low_q <= req.dividend[31:0];
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[31:0] : trial[31:0];
			low_q <= {low_q[30:0], qbit};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = low_q;

endmodule

@@ src/table_linear_interpolator.sv @@
`timescale 1ns / 1ps
// A load word is written to the table and gives no result. A query on an empty table
// goes straight to the finish state; else each table read passes through the read and
// evaluate states, and the query ends at the first or last entry when it lies outside
// the table, or else scans, multiplies, divides and finishes. The input is ready again
// in the cycle the result is raised; while the output holds a word, the block waits.
// Reset clears the control state and entries_in_use; the table is undefined.
module table_linear_interpolator #(
	parameter int TABLE_DEPTH = tli_pkg::TLI_TABLE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [6:0]   cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// entry_index, entry_wavelength, entry_absorption, query_wavelength, zero pad
	input  logic [103:0] s_axis_tdata,
	// kind
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// absorption_value
	output logic [31:0]  m_axis_tdata,
	// region
	output logic [1:0]   m_axis_tuser
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_EVAL = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DST  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_LAST  = 2'd1;
	localparam logic [1:0] PH_SCAN  = 2'd2;
	localparam logic [1:0] PH_LO    = 2'd3;

	logic [31:0] wl_mem [TABLE_DEPTH];
	logic [31:0] ab_mem [TABLE_DEPTH];
	logic [31:0] wl_rd_q;
	logic [31:0] ab_rd_q;

	logic [6:0]       cfg_q;
	logic [2:0]       state_q;
	logic [1:0]       phase_q;
	logic [AW-1:0]    rd_addr_q;
	logic [31:0]      q_q;
	logic [31:0]      w0_q, w1_q, a0_q, a1_q;
	logic [63:0]      prod_q;
	logic [31:0]      den_q;
	logic             neg_q;
	logic [31:0]      res_val_q;
	logic [1:0]       res_reg_q;
	logic             out_valid_q;
	logic [31:0]      out_data_q;
	logic [1:0]       out_user_q;

	logic [CMP_W-1:0] cfg_ext;
	logic [CMP_W-1:0] n_c;
	logic             in_acc;
	logic             is_load;
	logic [5:0]       in_idx;
	logic [31:0]      in_ew, in_ea, in_qw;
	logic [31:0]      diff_c, num_c;

	tli_pkg::div_req_t    div_req;
	tli_pkg::div_status_t div_st;
	logic [31:0]          div_quo;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign is_load       = (s_axis_tuser == tli_pkg::KIND_LOAD);
	assign in_idx        = s_axis_tdata[5:0];
	assign in_ew         = s_axis_tdata[37:6];
	assign in_ea         = s_axis_tdata[69:38];
	assign in_qw         = s_axis_tdata[101:70];

	assign cfg_ext = CMP_W'(cfg_q);
	assign n_c     = (cfg_ext > DEPTH_C) ? DEPTH_C : cfg_ext;

	assign diff_c = (a1_q >= a0_q) ? (a1_q - a0_q) : (a0_q - a1_q);
	assign num_c  = q_q - w0_q;

	assign div_req.start    = (state_q == ST_DST);
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = den_q;

	tli_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.status   (div_st),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (in_acc && is_load && (CMP_W'(in_idx) < DEPTH_C)) begin
			wl_mem[AW'(in_idx)] <= in_ew;
			ab_mem[AW'(in_idx)] <= in_ea;
		end
		wl_rd_q <= wl_mem[rd_addr_q];
		ab_rd_q <= ab_mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= '0;
			state_q     <= ST_IDLE;
			phase_q     <= PH_FIRST;
			rd_addr_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && !is_load) begin
						if (n_c == '0) begin
							state_q <= ST_FIN;
						end else begin
							rd_addr_q <= '0;
							phase_q   <= PH_FIRST;
							state_q   <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					unique case (phase_q)
						PH_FIRST: begin
							if (q_q <= wl_rd_q) begin
								state_q <= ST_FIN;
							end else begin
								rd_addr_q <= AW'(n_c - CMP_W'(1));
								phase_q   <= PH_LAST;
								state_q   <= ST_RD;
							end
						end
						PH_LAST: begin
							if (q_q >= wl_rd_q) begin
								state_q <= ST_FIN;
							end else begin
								rd_addr_q <= AW'(1);
								phase_q   <= PH_SCAN;
								state_q   <= ST_RD;
							end
						end
						PH_SCAN: begin
							if ((CMP_W'(rd_addr_q) < n_c - CMP_W'(1)) && (q_q > wl_rd_q)) begin
								rd_addr_q <= rd_addr_q + AW'(1);
							end else begin
								rd_addr_q <= rd_addr_q - AW'(1);
								phase_q   <= PH_LO;
							end
							state_q <= ST_RD;
						end
						PH_LO: begin
							state_q <= ST_MUL;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_MUL: begin
					state_q <= ST_DST;
				end
				ST_DST: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !is_load) begin
			q_q       <= in_qw;
			res_val_q <= '0;
			res_reg_q <= tli_pkg::REGION_EMPTY;
		end
		if (state_q == ST_EVAL) begin
			unique case (phase_q)
				PH_FIRST: begin
					res_val_q <= ab_rd_q;
					res_reg_q <= tli_pkg::REGION_BELOW;
				end
				PH_LAST: begin
					res_val_q <= '0;
					res_reg_q <= tli_pkg::REGION_ABOVE;
				end
				PH_SCAN: begin
					w1_q <= wl_rd_q;
					a1_q <= ab_rd_q;
				end
				PH_LO: begin
					w0_q <= wl_rd_q;
					a0_q <= ab_rd_q;
				end
				default: ;
			endcase
		end
		if (state_q == ST_MUL) begin
			prod_q <= {32'd0, diff_c} * {32'd0, num_c};
			den_q  <= w1_q - w0_q;
			neg_q  <= (a1_q < a0_q);
		end
		if (state_q == ST_DIV && div_st.done) begin
			res_val_q <= neg_q ? (a0_q - div_quo) : (a0_q + div_quo);
			res_reg_q <= tli_pkg::REGION_INTERP;
		end
		if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= res_val_q;
			out_user_q <= res_reg_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_div_idle_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_st.busy)
		else $error("divider busy while the block is idle");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == ST_FIN))
		else $error("result word raised outside the finish state");

	a_read_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (CMP_W'(rd_addr_q) < n_c))
		else $error("table read beyond the entries in use");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int unsigned WORD_TARGET   = 1400;
	localparam int unsigned SETTLE_CYCLES = 200;
	localparam int unsigned STALL_LIMIT   = 5000;

	typedef struct {
		logic [31:0] absorption;
		logic [1:0]  region;
	} absorption_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [6:0]   cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata = '0;
	logic         s_axis_tuser = tli_pkg::KIND_LOAD;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [31:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	logic [31:0]  model_wavelength [tli_pkg::TLI_TABLE_DEPTH];
	logic [31:0]  model_absorption [tli_pkg::TLI_TABLE_DEPTH];
	logic [6:0]   model_entry_count = '0;

	absorption_result_t pending_results [$];
	absorption_result_t front_result;

	int unsigned  words_sent = 0;
	int unsigned  burst_left = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  quiet_cycles = 0;
	logic [31:0]  ready_pattern = '1;
	logic [5:0]   stall_phase = '0;

	table_linear_interpolator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic absorption_result_t interpolate_absorption(logic [31:0] q);
		absorption_result_t r;
		int unsigned n;
		int unsigned i;
		logic [31:0] w0, w1, a0, a1;
		logic [63:0] num, den, mag;
		n = (model_entry_count > tli_pkg::TLI_TABLE_DEPTH) ? tli_pkg::TLI_TABLE_DEPTH
			: model_entry_count;
		r.absorption = '0;
		if (n == 0) begin
			r.region = tli_pkg::REGION_EMPTY;
			return r;
		end
		if (q <= model_wavelength[0]) begin
			r.region = tli_pkg::REGION_BELOW;
			r.absorption = model_absorption[0];
			return r;
		end
		if (q >= model_wavelength[n - 1]) begin
			r.region = tli_pkg::REGION_ABOVE;
			return r;
		end
		i = 1;
		while (i < n - 1 && q > model_wavelength[i])
			i++;
		w0 = model_wavelength[i - 1];
		w1 = model_wavelength[i];
		a0 = model_absorption[i - 1];
		a1 = model_absorption[i];
		den = {32'b0, w1} - {32'b0, w0};
		num = {32'b0, q} - {32'b0, w0};
		r.region = tli_pkg::REGION_INTERP;
		if (a1 >= a0) begin
			mag = ({32'b0, a1 - a0} * num) / den;
			r.absorption = a0 + mag[31:0];
		end else begin
			mag = ({32'b0, a0 - a1} * num) / den;
			r.absorption = a0 - mag[31:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		$display("mismatch on %s: expected %h, got %h at %0t", field, want, got, $realtime);
		mismatch_count++;
	endtask

	// The sender runs in bursts; between bursts tvalid may drop for a random gap.
	task automatic send_word(logic kind, logic [5:0] idx, logic [31:0] wl, logic [31:0] ab,
			logic [31:0] q);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		@(negedge clk);
		s_axis_tdata = {2'b00, q, ab, wl, idx};
		s_axis_tuser = kind;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (kind == tli_pkg::KIND_LOAD) begin
			model_wavelength[idx] = wl;
			model_absorption[idx] = ab;
		end else begin
			pending_results.insert(pending_results.size(), interpolate_absorption(q));
		end
		words_sent++;
		burst_left--;
	endtask

	task automatic load_entry(logic [5:0] idx, logic [31:0] wl, logic [31:0] ab);
		send_word(tli_pkg::KIND_LOAD, idx, wl, ab, $urandom);
	endtask

	task automatic ask_absorption(logic [31:0] q);
		send_word(tli_pkg::KIND_QUERY, 6'($urandom), $urandom, $urandom, q);
	endtask

	task automatic set_entries_in_use(logic [6:0] count);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_data = count;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model_entry_count = count;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_empty_table();
		set_entries_in_use(7'd0);
		ask_absorption(32'h0000_0000);
		ask_absorption(32'hFFFF_FFFF);
	endtask

	task automatic test_region_edges();
		load_entry(6'd0, 32'h0100_0000, 32'h0000_0100);
		load_entry(6'd1, 32'h0200_0000, 32'hFFFF_FFFF);
		load_entry(6'd2, 32'h0400_0000, 32'h0000_0000);
		load_entry(6'd3, 32'hF000_0000, 32'h8000_0000);
		set_entries_in_use(7'd4);
		ask_absorption(32'h0000_0000);
		ask_absorption(32'h0100_0000);
		ask_absorption(32'h0100_0001);
		ask_absorption(32'h0200_0000);
		ask_absorption(32'h0333_3333);
		ask_absorption(32'hF000_0000);
	endtask

	// Full-range spans push the product of the two differences close to 64 bits.
	task automatic test_extreme_span();
		load_entry(6'd0, 32'h0000_0000, 32'h0000_0000);
		load_entry(6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		set_entries_in_use(7'd2);
		ask_absorption(32'hFFFF_FFFE);
		ask_absorption(32'h0000_0001);
		load_entry(6'd0, 32'h0000_0000, 32'hFFFF_FFFF);
		load_entry(6'd1, 32'hFFFF_FFFF, 32'h0000_0000);
		ask_absorption(32'hFFFF_FFFE);
		ask_absorption(32'h8000_0000);
	endtask

	task automatic test_unsorted_table();
		load_entry(6'd0, 32'h0000_0010, 32'h0000_1000);
		load_entry(6'd1, 32'h0000_0080, 32'h0000_0000);
		load_entry(6'd2, 32'h0000_0040, 32'hFFFF_0000);
		load_entry(6'd3, 32'h0000_0020, 32'h0000_5000);
		load_entry(6'd4, 32'h0000_0100, 32'h0012_3456);
		set_entries_in_use(7'd5);
		ask_absorption(32'h0000_0030);
		ask_absorption(32'h0000_0090);
	endtask

	task automatic test_single_entry();
		set_entries_in_use(7'd1);
		ask_absorption(32'h0000_0010);
		ask_absorption(32'h0000_0011);
	endtask

	// Loads a fresh table for the given count, programs the count and then mixes
	// queries around the table points with stray loads and arbitrary queries.
	task automatic run_table_phase(logic [6:0] count, bit ascending, int unsigned n_words);
		int unsigned n;
		int unsigned k;
		logic [63:0] step_max;
		logic [63:0] base;
		logic [31:0] wl;
		logic [31:0] ab;
		n = (count > tli_pkg::TLI_TABLE_DEPTH) ? tli_pkg::TLI_TABLE_DEPTH : count;
		step_max = (64'hFFFF_FFFF / (n + 1)) >> $urandom_range(0, 20);
		if (step_max == 0)
			step_max = 1;
		base = 64'($urandom_range(0, 32'hFFFF_FFFF - step_max * (n + 1)));
		wl = base[31:0];
		for (int unsigned i = 0; i < n; i++) begin
			if (ascending)
				wl = wl + $urandom_range(0, step_max[31:0]);
			else
				wl = $urandom;
			ab = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0)
				: $urandom;
			load_entry(i[5:0], wl, ab);
		end
		set_entries_in_use(count);
		for (int unsigned j = 0; j < n_words; j++) begin
			k = (n == 0) ? 0 : $urandom_range(0, n - 1);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					if (n == 0)
						ask_absorption($urandom);
					else
						ask_absorption($urandom_range(model_wavelength[0],
							model_wavelength[n - 1]));
				end
				4, 5: begin
					ask_absorption(model_wavelength[k[5:0]] + $urandom_range(0, 2) - 1);
				end
				6: ask_absorption($urandom);
				7: ask_absorption($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
				8: load_entry(6'($urandom_range(0, tli_pkg::TLI_TABLE_DEPTH - 1)), $urandom,
					$urandom);
				default: ask_absorption($urandom);
			endcase
		end
	endtask

	task automatic test_full_table_clamp();
		run_table_phase(7'd64, 1'b1, 20);
		set_entries_in_use(7'd127);
		for (int i = 0; i < 10; i++)
			ask_absorption($urandom_range(model_wavelength[0], model_wavelength[63]));
		ask_absorption(model_wavelength[63] - 1);
		ask_absorption(model_wavelength[63]);
	endtask

	task automatic test_random_phases();
		logic [6:0] count;
		while (words_sent < WORD_TARGET) begin
			case ($urandom_range(0, 19))
				0: count = 7'd0;
				1: count = 7'd64;
				2: count = 7'($urandom_range(65, 127));
				3: count = 7'd1;
				4, 5, 6: count = 7'($urandom_range(2, 64));
				default: count = 7'($urandom_range(2, 12));
			endcase
			run_table_phase(count, $urandom_range(0, 4) != 0, $urandom_range(10, 40));
		end
	endtask

	always @(negedge clk) begin
		stall_phase <= stall_phase + 1'b1;
		if (stall_phase == 6'd0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern <= '1;
				1: ready_pattern <= $urandom;
				2: ready_pattern <= $urandom | $urandom;
				default: ready_pattern <= $urandom & $urandom;
			endcase
		end
		m_axis_tready <= ready_pattern[stall_phase[4:0]];
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unrequested word", 32'h0, m_axis_tdata);
			end else begin
				front_result = pending_results.pop_front();
				if (m_axis_tdata !== front_result.absorption)
					report_mismatch("absorption_value", front_result.absorption, m_axis_tdata);
				if (m_axis_tuser !== front_result.region)
					report_mismatch("region", {30'b0, front_result.region},
						{30'b0, m_axis_tuser});
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_empty_table();
		test_region_edges();
		test_extreme_span();
		test_unsorted_table();
		test_single_entry();
		test_full_table_clamp();
		test_random_phases();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
